// ===== rtl/morton_voxel_point_reorder_macros.svh =====
// Assertion macros for the Morton point reorder block.
`ifndef MORTON_VOXEL_POINT_REORDER_MACROS_SVH
`define MORTON_VOXEL_POINT_REORDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MVPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MVPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mvpr_pkg.sv =====
// Package: widths, defaults and status codes of the Morton point reorder block.
package mvpr_pkg;
  localparam int COORD_W        = 32;
  localparam int IDX_OUT_W      = 10;
  localparam int STATUS_W       = 2;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int AXIS_BITS_DEF  = 21;
  localparam logic [31:0] VOXEL_SCALE_RESET = 32'd65536;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
endpackage

// ===== rtl/mvpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mvpr_ram
  #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/morton_voxel_point_reorder.sv =====
// Morton (Z-order) point reorder: loads a point cloud, sorts it by voxel key, returns it.
// Loads are taken back to back while the block is idle; a successful load gives no
// result. The first read after loading runs a stable insertion sort over the store:
// per point, it fetches the point, runs three shared 32x32 multiplies with saturation,
// forms the key, places it and advances, and each key shifted in the key memory is
// read, compared and written back. Each read then passes through an order memory read
// and a point memory read before the result is handed to the output register; reads
// into an empty store and loads into a full one go straight to the output stage.
// There is no clearing pass after reset.
module morton_voxel_point_reorder
  import mvpr_pkg::*;
  #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int AXIS_BITS  = AXIS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [COORD_W-1:0]   x_coord,
  input  logic [COORD_W-1:0]   y_coord,
  input  logic [COORD_W-1:0]   z_coord,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_OUT_W-1:0] orig_index,
  output logic [COORD_W-1:0]   out_x,
  output logic [COORD_W-1:0]   out_y,
  output logic [COORD_W-1:0]   out_z,
  output logic                 final_flag,
  output logic [STATUS_W-1:0]  status
);
`include "morton_voxel_point_reorder_macros.svh"

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = 3 * AXIS_BITS;
  localparam int PW = 3 * COORD_W;
  localparam logic [31:0] CAP = 32'((64'd1 << AXIS_BITS) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_KRD, S_KMUL, S_KSAT, S_KEYSET, S_SRD, S_SCMP, S_NEXT,
    S_ORD_RD, S_ORD_LAT, S_PT_RD, S_PT_LAT, S_EMIT
  } state_t;

  state_t state;

  logic [31:0]         voxel_scale;
  logic [CW-1:0]       point_count;
  logic [CW-1:0]       read_pointer;
  logic                sorted_done;
  logic [COORD_W-1:0]  min_x, min_y, min_z;
  logic [IW-1:0]       sort_i;
  logic [IW-1:0]       sort_j;
  logic [1:0]          axis;
  logic [63:0]         prod;
  logic [AXIS_BITS-1:0] vox [3];
  logic [KW-1:0]       key_cur;
  logic [KW-1:0]       key_next;
  logic [IW-1:0]       idx_reg;

  // staged result
  logic [IW-1:0]        res_idx;
  logic [COORD_W-1:0]   res_x, res_y, res_z;
  logic                 res_final;
  logic [STATUS_W-1:0]  res_status;

  // memory ports
  logic          pt_we;
  logic [IW-1:0] pt_raddr;
  logic [PW-1:0] pt_rdata;
  logic          sk_we;
  logic [IW-1:0] sk_waddr;
  logic [KW-1:0] key_wdata;
  logic [IW-1:0] ord_wdata;
  logic [IW-1:0] sk_raddr;
  logic [KW-1:0] key_rdata;
  logic [IW-1:0] ord_rdata;

  logic              in_accept;
  logic              out_free;
  logic [COORD_W-1:0] rd_x, rd_y, rd_z;
  logic [COORD_W-1:0] axis_p, axis_min, diff;
  logic [31:0]        int_part;
  logic [AXIS_BITS-1:0] vox_sat;
  logic              load_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign load_full = (point_count == CW'(MAX_POINTS));

  assign rd_x = pt_rdata[COORD_W-1:0];
  assign rd_y = pt_rdata[2*COORD_W-1:COORD_W];
  assign rd_z = pt_rdata[PW-1:2*COORD_W];

  // point store is read at the sort index, or at the fetched order entry on reads
  assign pt_raddr = (state == S_PT_RD || state == S_PT_LAT) ? idx_reg : sort_i;
  // key and order memories read the insertion neighbor, or the read pointer
  assign sk_raddr = (state == S_SRD || state == S_SCMP) ? (sort_j - IW'(1))
                                                        : read_pointer[IW-1:0];

  assign pt_we = in_accept && !action && !load_full;

  // insertion write: shift the larger key up, or place the new key
  always_comb begin
    sk_we     = 1'b0;
    sk_waddr  = sort_j;
    key_wdata = key_cur;
    ord_wdata = sort_i;
    if (state == S_SRD && sort_j == '0) begin
      sk_we = 1'b1;
    end else if (state == S_SCMP) begin
      sk_we = 1'b1;
      if (key_rdata > key_cur) begin
        key_wdata = key_rdata;
        ord_wdata = ord_rdata;
      end
    end
  end

  // voxel index of the current axis
  always_comb begin
    case (axis)
      2'd0:    begin axis_p = rd_x; axis_min = min_x; end
      2'd1:    begin axis_p = rd_y; axis_min = min_y; end
      2'd2:    begin axis_p = rd_z; axis_min = min_z; end
      default: begin axis_p = rd_x; axis_min = min_x; end
    endcase
  end
  assign diff     = axis_p - axis_min;
  assign int_part = prod[63:32];
  assign vox_sat  = (int_part > CAP) ? CAP[AXIS_BITS-1:0] : int_part[AXIS_BITS-1:0];

  // Morton interleave, x in the lowest bit of each triple
  for (genvar g = 0; g < AXIS_BITS; g++) begin : g_ilv
    assign key_next[3*g]   = vox[0][g];
    assign key_next[3*g+1] = vox[1][g];
    assign key_next[3*g+2] = vox[2][g];
  end

  mvpr_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (point_count[IW-1:0]),
    .wdata ({z_coord, y_coord, x_coord}),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  mvpr_ram #(.WIDTH(KW), .DEPTH(MAX_POINTS)) u_key_ram (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (key_wdata),
    .raddr (sk_raddr),
    .rdata (key_rdata)
  );

  mvpr_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_order_ram (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (ord_wdata),
    .raddr (sk_raddr),
    .rdata (ord_rdata)
  );

  // control sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      voxel_scale  <= VOXEL_SCALE_RESET;
      point_count  <= '0;
      read_pointer <= '0;
      sorted_done  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        voxel_scale <= cfg_data;
      end
      // output valid: load a staged result, or drop a delivered one
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            res_idx   <= '0;
            res_x     <= '0;
            res_y     <= '0;
            res_z     <= '0;
            res_final <= 1'b0;
            if (!action) begin
              if (load_full) begin
                res_status <= STATUS_FULL;
                state      <= S_EMIT;
              end else begin
                if (point_count == '0) begin
                  min_x <= x_coord;
                  min_y <= y_coord;
                  min_z <= z_coord;
                end else begin
                  if ($signed(x_coord) < $signed(min_x)) min_x <= x_coord;
                  if ($signed(y_coord) < $signed(min_y)) min_y <= y_coord;
                  if ($signed(z_coord) < $signed(min_z)) min_z <= z_coord;
                end
                point_count  <= point_count + CW'(1);
                sorted_done  <= 1'b0;
                read_pointer <= '0;
              end
            end else if (point_count == '0) begin
              res_status <= STATUS_EMPTY;
              state      <= S_EMIT;
            end else if (!sorted_done) begin
              sort_i <= '0;
              state  <= S_KRD;
            end else begin
              state <= S_ORD_RD;
            end
          end
        end
        S_KRD: begin
          axis  <= 2'd0;
          state <= S_KMUL;
        end
        S_KMUL: begin
          prod  <= 64'(diff) * 64'(voxel_scale);
          state <= S_KSAT;
        end
        S_KSAT: begin
          vox[axis] <= vox_sat;
          if (axis == 2'd2) begin
            state <= S_KEYSET;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_KMUL;
          end
        end
        S_KEYSET: begin
          key_cur <= key_next;
          sort_j  <= sort_i;
          state   <= S_SRD;
        end
        S_SRD: begin
          state <= (sort_j == '0) ? S_NEXT : S_SCMP;
        end
        S_SCMP: begin
          if (key_rdata > key_cur) begin
            sort_j <= sort_j - IW'(1);
            state  <= S_SRD;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (CW'(sort_i) + CW'(1) == point_count) begin
            sorted_done  <= 1'b1;
            read_pointer <= '0;
            state        <= S_ORD_RD;
          end else begin
            sort_i <= sort_i + IW'(1);
            state  <= S_KRD;
          end
        end
        S_ORD_RD: begin
          state <= S_ORD_LAT;
        end
        S_ORD_LAT: begin
          idx_reg <= ord_rdata;
          state   <= S_PT_RD;
        end
        S_PT_RD: begin
          state <= S_PT_LAT;
        end
        S_PT_LAT: begin
          res_idx    <= idx_reg;
          res_x      <= rd_x;
          res_y      <= rd_y;
          res_z      <= rd_z;
          res_status <= STATUS_OK;
          res_final  <= (read_pointer + CW'(1) == point_count);
          if (read_pointer + CW'(1) >= point_count) begin
            point_count  <= '0;
            read_pointer <= '0;
            sorted_done  <= 1'b0;
          end else begin
            read_pointer <= read_pointer + CW'(1);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            orig_index <= IDX_OUT_W'(32'(res_idx));
            out_x      <= res_x;
            out_y      <= res_y;
            out_z      <= res_z;
            final_flag <= res_final;
            status     <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `MVPR_ASSERT_NOW(a_count_bound, 1'b1, point_count <= CW'(MAX_POINTS), "point count overflow")
  `MVPR_ASSERT_NOW(a_sorted_nonempty, sorted_done, point_count != '0, "sorted with empty store")
  `MVPR_ASSERT_NOW(a_ptr_bound, point_count != '0, read_pointer < point_count, "read pointer out of range")
  `MVPR_ASSERT_NOW(a_shift_nonzero, state == S_SCMP, sort_j != '0, "shift compare at slot zero")
  `MVPR_ASSERT_NEXT(a_emit_fills, state == S_EMIT && out_free, out_valid, "result not delivered")
endmodule

// ===== tb/morton_voxel_point_reorder_test.sv =====
// Self-checking testbench for the Morton point reorder block: directed table, random clouds, full store.
module morton_voxel_point_reorder_test;
  import mvpr_pkg::*;

  localparam int CAPACITY   = MAX_POINTS_DEF;
  localparam int AXIS_W     = AXIS_BITS_DEF;
  localparam int IDLE_WAIT  = 40;
  localparam int WATCHDOG   = 200000;
  localparam int RAND_ITEMS = 1300;
  localparam int FILL_READS = 3;
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] idx;
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    logic [COORD_W-1:0]   pz;
    logic                 fin;
    logic [STATUS_W-1:0]  st;
  } point_result_t;

  typedef struct packed {
    logic                act;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [COORD_W-1:0]  pz;
    logic                typed;
    point_result_t       res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [COORD_W-1:0] x_coord = '0, y_coord = '0, z_coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_OUT_W-1:0] orig_index;
  logic [COORD_W-1:0] out_x, out_y, out_z;
  logic final_flag;
  logic [STATUS_W-1:0] status;

  morton_voxel_point_reorder dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
    .out_valid(out_valid), .out_stall(out_stall), .orig_index(orig_index),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .final_flag(final_flag), .status(status)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [31:0]        voxel_scale;
  logic [COORD_W-1:0] cloud_x [CAPACITY];
  logic [COORD_W-1:0] cloud_y [CAPACITY];
  logic [COORD_W-1:0] cloud_z [CAPACITY];
  int                 z_order [CAPACITY];
  logic [62:0]        z_key   [CAPACITY];
  int                 cloud_size;
  logic signed [COORD_W-1:0] lo_x, lo_y, lo_z;
  int                 read_pos;
  logic               order_valid;

  point_result_t pending_points[$];
  int errors = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  function automatic logic [AXIS_W-1:0] grid_index(logic [31:0] p, logic [31:0] lo);
    logic [31:0] diff;
    logic [63:0] prod;
    diff = p - lo;
    prod = {32'd0, diff} * {32'd0, voxel_scale};
    if (prod[63:32] > (2**AXIS_W - 1)) return '1;
    return prod[AXIS_W-1+32:32];
  endfunction

  function automatic logic [62:0] morton_key(logic [AXIS_W-1:0] vx, logic [AXIS_W-1:0] vy,
                                             logic [AXIS_W-1:0] vz);
    logic [62:0] k;
    k = '0;
    for (int i = 0; i < AXIS_W; i++) begin
      k[3*i] = vx[i];
      k[3*i+1] = vy[i];
      k[3*i+2] = vz[i];
    end
    return k;
  endfunction

  // stable insertion sort over the stored cloud
  task automatic sort_cloud();
    logic [62:0] k;
    int j;
    for (int i = 0; i < cloud_size; i++) begin
      k = morton_key(grid_index(cloud_x[i], lo_x), grid_index(cloud_y[i], lo_y),
                     grid_index(cloud_z[i], lo_z));
      j = i;
      while (j > 0 && z_key[j-1] > k) begin
        z_key[j] = z_key[j-1];
        z_order[j] = z_order[j-1];
        j--;
      end
      z_key[j] = k;
      z_order[j] = i;
    end
  endtask

  // advance the predictor by one accepted transaction; returns 1 when a result is due
  task automatic reorder_step(input logic act, input logic [31:0] px, py, pz,
                              output logic has_res, output point_result_t res);
    int id;
    res = '0;
    has_res = 1'b0;
    if (act == ACT_LOAD) begin
      if (cloud_size >= CAPACITY) begin
        res.st = STATUS_FULL;
        has_res = 1'b1;
        return;
      end
      if (cloud_size == 0) begin
        lo_x = px; lo_y = py; lo_z = pz;
      end else begin
        if ($signed(px) < lo_x) lo_x = px;
        if ($signed(py) < lo_y) lo_y = py;
        if ($signed(pz) < lo_z) lo_z = pz;
      end
      cloud_x[cloud_size] = px;
      cloud_y[cloud_size] = py;
      cloud_z[cloud_size] = pz;
      cloud_size++;
      order_valid = 1'b0;
      read_pos = 0;
      return;
    end
    has_res = 1'b1;
    if (cloud_size == 0) begin
      res.st = STATUS_EMPTY;
      return;
    end
    if (!order_valid) begin
      sort_cloud();
      order_valid = 1'b1;
      read_pos = 0;
    end
    id = z_order[read_pos];
    res.idx = id[IDX_OUT_W-1:0];
    res.px = cloud_x[id];
    res.py = cloud_y[id];
    res.pz = cloud_z[id];
    res.fin = (read_pos + 1 == cloud_size);
    res.st = STATUS_OK;
    read_pos++;
    if (read_pos >= cloud_size) begin
      cloud_size = 0;
      read_pos = 0;
      order_valid = 1'b0;
    end
  endtask

  // random gap before a transaction, mostly none, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // drive one input transaction and predict on acceptance
  task automatic send_point(input logic act, input logic [31:0] px, py, pz,
                            input logic typed, input point_result_t typed_res);
    int gap;
    logic has_res;
    point_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    x_coord <= px;
    y_coord <= py;
    z_coord <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reorder_step(act, px, py, pz, has_res, res);
    if (has_res) pending_points.insert(pending_points.size(), typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic load_point(input logic [31:0] px, py, pz);
    send_point(ACT_LOAD, px, py, pz, 1'b0, '0);
  endtask

  task automatic read_point();
    send_point(ACT_READ, $urandom, $urandom, $urandom, 1'b0, '0);
  endtask

  // wait until the block is quiet, then write the voxel scale
  task automatic set_scale(input logic [31:0] scale);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= scale;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    voxel_scale = scale;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 6))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      3: return $urandom;
      4: return 32'h0000_4000;
      default: return VOXEL_SCALE_RESET;
    endcase
  endfunction

  // output side: random stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: stall_left <= $urandom_range(0, 2);
        3: stall_left <= $urandom_range(10, 40);
        default: stall_left <= 0;
      endcase
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    point_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result idx=%0d status=%0d", $time, orig_index, status);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (orig_index !== want.idx) begin
          $display("%0t: orig_index expected %0d actual %0d", $time, want.idx, orig_index);
          errors++;
        end
        if (out_x !== want.px) begin
          $display("%0t: out_x expected %h actual %h", $time, want.px, out_x);
          errors++;
        end
        if (out_y !== want.py) begin
          $display("%0t: out_y expected %h actual %h", $time, want.py, out_y);
          errors++;
        end
        if (out_z !== want.pz) begin
          $display("%0t: out_z expected %h actual %h", $time, want.pz, out_z);
          errors++;
        end
        if (final_flag !== want.fin) begin
          $display("%0t: final_flag expected %0d actual %0d", $time, want.fin, final_flag);
          errors++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  stim_row_t directed[] = '{
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 1'b1, '{10'd0, 32'h0, 32'h0, 32'h0, 1'b0, STATUS_EMPTY}},
    '{ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, '0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 1'b1,
      '{10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, STATUS_OK}},
    '{ACT_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{10'd0, 32'h0, 32'h0, 32'h0, 1'b0, STATUS_EMPTY}},
    '{ACT_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_LOAD, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ACT_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
    '{ACT_LOAD, 32'h0001_0000, 32'h0002_0000, 32'h0, 1'b0, '0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    // load in the middle of a read pass restarts the order
    '{ACT_LOAD, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 1'b1, '{10'd0, 32'h0, 32'h0, 32'h0, 1'b0, STATUS_EMPTY}}
  };

  initial begin
    int n_pts;
    int mid_read;
    logic [31:0] base_x, base_y, base_z;
    logic wide;
    voxel_scale = VOXEL_SCALE_RESET;
    cloud_size = 0;
    read_pos = 0;
    order_valid = 1'b0;
    lo_x = '0; lo_y = '0; lo_z = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at the reset scale
    foreach (directed[i])
      send_point(directed[i].act, directed[i].px, directed[i].py, directed[i].pz,
                 directed[i].typed, directed[i].res);

    // random points with zero scale give equal keys and keep load order
    set_scale(32'd0);
    for (int i = 0; i < 5; i++) load_point($urandom, $urandom, $urandom);
    while (cloud_size > 0) read_point();

    // random clouds, leaving room in the item budget for the full store
    while (items_sent < RAND_ITEMS - CAPACITY - FILL_READS - 1) begin
      if ($urandom_range(0, 3) == 0) set_scale(pick_scale());
      n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
      mid_read = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n_pts) : -1;
      wide = ($urandom_range(0, 3) == 0);
      base_x = $urandom; base_y = $urandom; base_z = $urandom;
      if ($urandom_range(0, 9) == 0) read_point();
      for (int i = 0; i < n_pts; i++) begin
        if (wide) load_point($urandom, $urandom, $urandom);
        else load_point(base_x + $urandom_range(0, 32'h0004_0000),
                        base_y + $urandom_range(0, 32'h0004_0000),
                        base_z + $urandom_range(0, 32'h0004_0000));
        if (i + 1 == mid_read) begin
          read_point();
          if ($urandom_range(0, 1) == 0) read_point();
        end
      end
      // usually drain the whole cloud, sometimes leave some for the next one
      if ($urandom_range(0, 7) != 0) begin
        while (cloud_size > 0) read_point();
      end else begin
        repeat ($urandom_range(1, 3)) read_point();
      end
    end
    while (cloud_size > 0) read_point();

    // full store: equal points so the sort does no shifting; one load past capacity, then read the head of the order
    set_scale(32'hFFFF_FFFF);
    for (int i = 0; i < CAPACITY; i++) load_point(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    load_point($urandom, $urandom, $urandom);
    repeat (FILL_READS) read_point();

    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== morton_voxel_point_reorder.f =====
+incdir+rtl
rtl/mvpr_pkg.sv
rtl/mvpr_ram.sv
rtl/morton_voxel_point_reorder.sv
tb/morton_voxel_point_reorder_test.sv
